// ===== hw/rtl/bedc_pkg.sv =====
// ----------------------------------------------------------------------------
// bedc_pkg
// Shared types and constants for the nearest-barcode edit-distance matcher.
// ----------------------------------------------------------------------------
package bedc_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int MAX_BASES   = 16;
    localparam int BASE_BITS   = 3;

    localparam int SEQ_W  = 48;
    localparam int LEN_W  = 5;
    localparam int ID_W   = 10;
    localparam int IDX_W  = 8;
    localparam int CFG_W  = 9;
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W  = $clog2(MAX_BASES);
    localparam int DIST_W = $clog2(MAX_BASES + 2);

    typedef logic [BASE_BITS-1:0] t_base;
    typedef logic [DIST_W-1:0]    t_dist;
    typedef logic [ID_W-1:0]      t_id;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_EXACT     = 2'd0,
        ST_CORRECTED = 2'd1,
        ST_UNCLEAR   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EMIT,
        S_DRAIN,
        S_DONE
    } t_state;

    // One stored base (or an entry's leading boundary) moving down the row.
    typedef struct packed {
        logic  valid;
        logic  bnd;
        logic  last;
        t_base base;
        t_dist cost;
        t_id   id;
    } t_elem;

    typedef struct packed {
        t_id                 id;
        logic [LEN_W-1:0]    len;
        logic [SEQ_W-1:0]    bases;
    } t_entry;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        clamp_len = (len > LEN_W'(MAX_BASES)) ? LEN_W'(MAX_BASES) : len;
    endfunction

endpackage

// ===== hw/rtl/bedc_cell.sv =====
// ----------------------------------------------------------------------------
// bedc_cell
// One row of the edit-distance matrix: holds one query base.
// ----------------------------------------------------------------------------
module bedc_cell
    import bedc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_load,
    input  t_base i_qbase,
    input  logic  i_act,
    input  t_elem i_elem,
    output t_elem o_elem
);

    t_base r_qbase;
    logic  r_act;
    t_dist r_own;
    t_dist r_diag;
    t_elem r_out;

    logic [DIST_W:0] w_up1;
    logic [DIST_W:0] w_own1;
    logic [DIST_W:0] w_sub;
    logic [DIST_W:0] w_min;
    t_dist           w_d;
    t_elem           w_next;

    always_comb begin
        w_up1  = {1'b0, i_elem.cost} + 1'b1;
        w_own1 = {1'b0, r_own} + 1'b1;
        w_sub  = {1'b0, r_diag} + (DIST_W+1)'(i_elem.base != r_qbase);
        w_min  = (w_own1 < w_up1) ? w_own1 : w_up1;
        w_min  = (w_sub < w_min) ? w_sub : w_min;
        // boundary column: D[i][0] = D[i-1][0] + 1
        w_d    = i_elem.bnd ? w_up1[DIST_W-1:0] : w_min[DIST_W-1:0];
        w_next = i_elem;
        if (r_act) begin
            w_next.cost = w_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_qbase <= i_qbase;
            r_act   <= i_act;
        end
        if (i_elem.valid && r_act) begin
            r_own  <= w_d;
            r_diag <= i_elem.cost;
        end
    end

    assign o_elem = r_out;

endmodule

// ===== hw/rtl/bedc_chain.sv =====
// ----------------------------------------------------------------------------
// bedc_chain
// Row of MAX_BASES cells; cell g holds query base g, active up to the length.
// ----------------------------------------------------------------------------
module bedc_chain
    import bedc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [SEQ_W-1:0] i_qbases,
    input  logic [LEN_W-1:0] i_qlen,
    input  t_elem            i_elem,
    output t_elem            o_elem
);

    t_elem w_link [0:MAX_BASES];

    assign w_link[0] = i_elem;

    for (genvar g = 0; g < MAX_BASES; g++) begin : g_cell
        bedc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (i_load),
            .i_qbase (i_qbases[g*BASE_BITS +: BASE_BITS]),
            .i_act   (LEN_W'(g + 1) <= i_qlen),
            .i_elem  (w_link[g]),
            .o_elem  (w_link[g+1])
        );
    end

    assign o_elem = w_link[MAX_BASES];

endmodule

// ===== hw/rtl/barcode_edit_distance_corrector.sv =====
// ----------------------------------------------------------------------------
// barcode_edit_distance_corrector
// Nearest known barcode by Levenshtein distance, with a loadable table.
// ----------------------------------------------------------------------------
// A write item (operation 0) stores bases, length and id in one table slot.
// A query item (operation 1) is loaded into a row of MAX_BASES cells, one
// query base per cell; slots 0 .. min(entries_in_use, TABLE_DEPTH)-1 are then
// read from the table one after another and streamed through the row, one
// stored base per cycle, each entry preceded by a boundary item. Each cell
// computes one row of the edit-distance matrix as the stream passes and
// registers the stream, so a distance leaves the end of the row after passing
// the registers of all MAX_BASES cells. The finish step waits while an earlier
// result still sits unaccepted in the output register. One item is worked on
// at a time; a finished result waits in the output register while the next
// item is taken. A query may read only slots that were written before.
// The user must write entries_in_use only while the block is idle; the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
module barcode_edit_distance_corrector
    import bedc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input items
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_operation,
    input  logic [IDX_W-1:0] i_entry_index,
    input  logic [SEQ_W-1:0] i_sequence_bases,
    input  logic [LEN_W-1:0] i_sequence_length,
    input  logic [ID_W-1:0]  i_entry_id,
    // result items
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [ID_W-1:0]  o_barcode_id,
    output logic [1:0]       o_match_status,
    output logic [DIST_W-1:0] o_best_distance,
    // configuration
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    // table
    t_entry r_mem [0:TABLE_DEPTH-1];
    t_entry r_rd;

    t_state r_state, n_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [CNT_W-1:0]  r_n;       // slots searched by the current query
    logic [ADDR_W-1:0] r_k, n_k;
    logic [LEN_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_done;    // distances collected so far

    // collector
    t_dist     r_best;
    logic [1:0] r_occ;            // 0, 1, or 2 for "two or more"
    t_id       r_bid;

    // output register
    logic      r_ovalid;
    t_id       r_oid;
    t_status   r_ostat;
    t_dist     r_obest;

    logic              w_in_acc;
    logic              w_query;
    logic              w_load_out;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [CNT_W-1:0]  w_k1;
    logic [POS_W-1:0]  w_pos;
    t_elem             w_feed;
    t_elem             w_tail;
    t_id               w_res_id;
    t_status           w_res_stat;
    t_dist             w_res_best;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_query    = w_in_acc && (i_operation == OP_QUERY);
    assign w_k1       = CNT_W'(r_k) + 1'b1;
    assign w_pos      = POS_W'(r_j - 1'b1);

    // ---- configuration register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg <= i_cfg_data;
        end
    end

    // ---- table write and registered read ----
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_operation == OP_WRITE)) begin
            r_mem[ADDR_W'(i_entry_index)] <= '{id:    i_entry_id,
                                               len:   clamp_len(i_sequence_length),
                                               bases: i_sequence_bases};
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // ---- sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        n_j        = r_j;
        w_rd_addr  = r_k;
        w_feed     = '0;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_query) begin
                    n_k     = '0;
                    n_state = (r_cfg == '0) ? S_DRAIN : S_READ;
                end
            end
            S_READ: begin
                n_j     = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                w_feed.valid = 1'b1;
                w_feed.bnd   = (r_j == '0);
                w_feed.last  = (r_j == r_rd.len);
                w_feed.base  = r_rd.bases[w_pos*BASE_BITS +: BASE_BITS];
                w_feed.cost  = DIST_W'(r_j);
                w_feed.id    = r_rd.id;
                if (r_j == r_rd.len) begin
                    n_j       = '0;
                    n_k       = w_k1[ADDR_W-1:0];
                    w_rd_addr = w_k1[ADDR_W-1:0];
                    if (w_k1 == r_n) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DRAIN: begin
                if (r_done == r_n) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        r_j <= n_j;
        if (w_query) begin
            r_n <= (r_cfg > CFG_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(r_cfg);
        end
    end

    // ---- cell row ----
    bedc_chain u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_query),
        .i_qbases (i_sequence_bases),
        .i_qlen   (clamp_len(i_sequence_length)),
        .i_elem   (w_feed),
        .o_elem   (w_tail)
    );

    // ---- collector: keep the smallest distance and count its holders ----
    always_ff @(posedge i_clk) begin
        if (w_query) begin
            r_done <= '0;
            r_best <= DIST_W'(MAX_BASES + 1);
            r_occ  <= 2'd0;
            r_bid  <= '0;
        end else if (w_tail.valid && w_tail.last) begin
            r_done <= r_done + 1'b1;
            if (w_tail.cost < r_best) begin
                r_best <= w_tail.cost;
                r_bid  <= w_tail.id;
                r_occ  <= 2'd1;
            end else if (w_tail.cost == r_best) begin
                r_occ  <= 2'd2;
            end
        end
    end

    always_comb begin
        priority if (r_occ == 2'd0) begin
            w_res_id   = '0;
            w_res_stat = ST_UNCLEAR;
            w_res_best = DIST_W'(MAX_BASES);
        end else if (r_occ == 2'd1) begin
            w_res_id   = r_bid;
            w_res_stat = (r_best == '0) ? ST_EXACT : ST_CORRECTED;
            w_res_best = r_best;
        end else begin
            w_res_id   = '0;
            w_res_stat = ST_UNCLEAR;
            w_res_best = r_best;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_oid   <= w_res_id;
            r_ostat <= w_res_stat;
            r_obest <= w_res_best;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_barcode_id    = r_oid;
    assign o_match_status  = r_ostat;
    assign o_best_distance = r_obest;

    // ---- checks ----
    a_tail_in_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> (r_state == S_EMIT || r_state == S_DRAIN))
        else $error("distance left the cell row outside a query");

    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_done <= r_n))
        else $error("more distances collected than slots searched");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the finish step");

endmodule

// ===== sim/barcode_edit_distance_corrector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barcode_edit_distance_corrector_tb
// Self-checking bench for the nearest-barcode edit-distance matcher. Table
// writes and queries go in over valid/ready with random gaps and output
// stalls. Each query's result is typed in or predicted by a local edit-distance
// search over a shadow copy of the table and compared field by field, in order.
// ----------------------------------------------------------------------------
module barcode_edit_distance_corrector_tb
    import bedc_pkg::*;
();

    localparam int LIMIT_CYCLES = 12_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_operation = 1'b0;
    logic [IDX_W-1:0]  i_entry_index = '0;
    logic [SEQ_W-1:0]  i_sequence_bases = '0;
    logic [LEN_W-1:0]  i_sequence_length = '0;
    logic [ID_W-1:0]   i_entry_id = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [ID_W-1:0]   o_barcode_id;
    logic [1:0]        o_match_status;
    logic [DIST_W-1:0] o_best_distance;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data = '0;

    barcode_edit_distance_corrector u_dut (.*);

    always #5 i_clk = ~i_clk;

    // One expected match result.
    typedef struct {
        t_id     id;
        t_status status;
        int      cost;
    } t_match;

    // One stimulus row; has_exp marks rows whose answer is typed in.
    typedef struct {
        t_op              op;
        int               slot;
        logic [SEQ_W-1:0] bases;
        logic [LEN_W-1:0] len;
        t_id              id;
        bit               has_exp;
        t_match           exp;
    } t_row;

    // Shadow table and register.
    logic [SEQ_W-1:0] shadow_bases [TABLE_DEPTH];
    int               shadow_len   [TABLE_DEPTH];
    t_id              shadow_id    [TABLE_DEPTH];
    int               slots_searched;

    t_match pending_matches[$];
    int     mismatches;
    int     results_seen;
    int     queries_sent;
    int     cycle_count;
    bit     long_stall_req;
    int     stall_kind;                  // 0 random, 1 always ready

    // --------------------------------------------------------------------
    // Prediction
    // --------------------------------------------------------------------
    function automatic int clip_len(logic [LEN_W-1:0] l);
        return (l > MAX_BASES) ? MAX_BASES : int'(l);
    endfunction

    function automatic int lev_cost(logic [SEQ_W-1:0] a, int la,
                                    logic [SEQ_W-1:0] b, int lb);
        int row_prev [MAX_BASES+1];
        int row_cur  [MAX_BASES+1];
        int best;
        for (int j = 0; j <= lb; j++) row_prev[j] = j;
        for (int i = 1; i <= la; i++) begin
            row_cur[0] = i;
            for (int j = 1; j <= lb; j++) begin
                best = row_prev[j] + 1;
                if (row_cur[j-1] + 1 < best) best = row_cur[j-1] + 1;
                if (row_prev[j-1] + ((a[(i-1)*BASE_BITS +: BASE_BITS] ==
                        b[(j-1)*BASE_BITS +: BASE_BITS]) ? 0 : 1) < best)
                    best = row_prev[j-1] +
                        ((a[(i-1)*BASE_BITS +: BASE_BITS] ==
                          b[(j-1)*BASE_BITS +: BASE_BITS]) ? 0 : 1);
                row_cur[j] = best;
            end
            row_prev = row_cur;
        end
        return row_prev[lb];
    endfunction

    function automatic t_match nearest_barcode(logic [SEQ_W-1:0] q, int ql);
        t_match m;
        int best, ties, d, n;
        best = MAX_BASES + 1;
        ties = 0;
        m.id = '0;
        n = (slots_searched > TABLE_DEPTH) ? TABLE_DEPTH : slots_searched;
        for (int k = 0; k < n; k++) begin
            d = lev_cost(q, ql, shadow_bases[k], shadow_len[k]);
            if (d < best) begin
                best = d;
                m.id = shadow_id[k];
                ties = 1;
            end else if (d == best) begin
                ties++;
            end
        end
        if (ties == 0) begin
            m.id = '0;
            m.status = ST_UNCLEAR;
            best = MAX_BASES;
        end else if (ties > 1) begin
            m.id = '0;
            m.status = ST_UNCLEAR;
        end else begin
            m.status = (best == 0) ? ST_EXACT : ST_CORRECTED;
        end
        m.cost = best;
        return m;
    endfunction

    // --------------------------------------------------------------------
    // Checking
    // --------------------------------------------------------------------
    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            t_match e;
            results_seen++;
            if (pending_matches.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = pending_matches.pop_front();
                if (o_barcode_id !== e.id)
                    report_mismatch($sformatf("id %0d, expected %0d", o_barcode_id, e.id));
                if (o_match_status !== e.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_match_status, e.status));
                if (o_best_distance !== DIST_W'(e.cost))
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              o_best_distance, e.cost));
            end
        end
    end

    // Receiver: random stalls, a long hold-off on request, or always ready.
    always @(posedge i_clk) begin
        int r;
        if (long_stall_req) begin
            i_out_ready <= 1'b0;
            repeat (3000) @(posedge i_clk);
            long_stall_req = 1'b0;
        end else if (stall_kind == 1) begin
            i_out_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 55) i_out_ready <= 1'b1;
            else if (r < 97) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(20, 120)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // --------------------------------------------------------------------
    // Sender
    // --------------------------------------------------------------------
    // Valid stays high from one item to the next unless a gap is taken;
    // wait_drained drops it before any pause.
    task automatic send_item(t_row r, bit allow_gap);
        int g;
        if (allow_gap) begin
            g = $urandom_range(0, 99);
            if (g >= 60) begin
                i_in_valid <= 1'b0;
                if (g < 96) repeat ($urandom_range(1, 3)) @(posedge i_clk);
                else repeat ($urandom_range(15, 80)) @(posedge i_clk);
            end
        end
        i_in_valid        <= 1'b1;
        i_operation       <= r.op;
        i_entry_index     <= IDX_W'(r.slot);
        i_sequence_bases  <= r.bases;
        i_sequence_length <= r.len;
        i_entry_id        <= r.id;
        do @(posedge i_clk); while (!o_in_ready);
        if (r.op == OP_WRITE) begin
            shadow_bases[r.slot] = r.bases;
            shadow_len[r.slot]   = clip_len(r.len);
            shadow_id[r.slot]    = r.id;
        end else begin
            queries_sent++;
            if (r.has_exp) pending_matches.push_back(r.exp);
            else pending_matches.push_back(nearest_barcode(r.bases, clip_len(r.len)));
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_entries_in_use(int n);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= CFG_W'(n);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        slots_searched = n;
    endtask

    function automatic t_row write_row(int slot, logic [SEQ_W-1:0] b,
                                       logic [LEN_W-1:0] l, t_id id);
        t_row r;
        r.op = OP_WRITE; r.slot = slot; r.bases = b; r.len = l; r.id = id;
        r.has_exp = 1'b0;
        r.exp = '{id: '0, status: ST_UNCLEAR, cost: 0};
        return r;
    endfunction

    function automatic t_row query_row(logic [SEQ_W-1:0] b, logic [LEN_W-1:0] l,
                                       bit fixed, t_id id, t_status st, int d);
        t_row r;
        r = write_row(0, b, l, '0);
        r.op = OP_QUERY;
        r.has_exp = fixed;
        r.exp = '{id: id, status: st, cost: d};
        return r;
    endfunction

    // Random bases; the random query below is often a stored slot's sequence with edits.
    function automatic logic [SEQ_W-1:0] random_bases();
        return SEQ_W'({$urandom(), $urandom()});
    endfunction

    function automatic t_row random_query(int n);
        t_row r;
        int k, edits, p;
        logic [SEQ_W-1:0] b;
        int l;
        if (n > 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, n - 1);
            b = shadow_bases[k];
            l = shadow_len[k];
            edits = $urandom_range(0, 3);
            for (int e = 0; e < edits; e++) begin
                p = $urandom_range(0, MAX_BASES - 1);
                b[p*BASE_BITS +: BASE_BITS] = BASE_BITS'($urandom());
            end
            if ($urandom_range(0, 3) == 0) l = $urandom_range(1, MAX_BASES);
            // random high bits above the length are ignored
            b = b | (random_bases() & ~((SEQ_W'(1) << (l * BASE_BITS)) - 1));
            r = query_row(b, LEN_W'(l), 1'b0, '0, ST_UNCLEAR, 0);
        end else begin
            r = query_row(random_bases(), LEN_W'($urandom_range(0, 31)), 1'b0, '0,
                          ST_UNCLEAR, 0);
        end
        return r;
    endfunction

    // --------------------------------------------------------------------
    // Main sequence
    // --------------------------------------------------------------------
    initial begin
        t_row dir_rows[$];
        t_row r;
        int n, phase_items;
        int k, o;
        int sizes [5];

        sizes = '{3, 1, 24, 8, 256};
        mismatches = 0; results_seen = 0; queries_sent = 0; cycle_count = 0;
        long_stall_req = 1'b0; stall_kind = 0; slots_searched = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty search straight after reset.
        dir_rows.push_back(query_row('0, 5'd4, 1'b1, '0, ST_UNCLEAR, MAX_BASES));
        // Fill slots 0..3: extremes of length, base codes and id.
        dir_rows.push_back(write_row(0, '0, 5'd1, 10'd1));
        dir_rows.push_back(write_row(1, {SEQ_W{1'b1}}, 5'd16, 10'd999));
        dir_rows.push_back(write_row(2, 48'h0000_0000_0FAC, 5'd31, 10'd512));
        dir_rows.push_back(write_row(3, 48'h0000_0000_0FAC, 5'd0, 10'd0));
        foreach (dir_rows[i]) send_item(dir_rows[i], 1'b0);
        dir_rows.delete();

        write_entries_in_use(0);
        dir_rows.push_back(query_row({SEQ_W{1'b1}}, 5'd16, 1'b1, '0, ST_UNCLEAR,
                                     MAX_BASES));
        foreach (dir_rows[i]) send_item(dir_rows[i], 1'b0);
        dir_rows.delete();

        write_entries_in_use(2);
        // exact hit on slot 1, with length saturation on the query
        dir_rows.push_back(query_row({SEQ_W{1'b1}}, 5'd31, 1'b1, 10'd999, ST_EXACT, 0));
        // exact hit on slot 0, base bits above the length ignored
        dir_rows.push_back(query_row(48'hFFFF_FFFF_FFF8, 5'd1, 1'b1, 10'd1, ST_EXACT, 0));
        dir_rows.push_back(query_row('0, 5'd0, 1'b0, '0, ST_UNCLEAR, 0));
        dir_rows.push_back(query_row(48'h7, 5'd2, 1'b0, '0, ST_UNCLEAR, 0));
        foreach (dir_rows[i]) send_item(dir_rows[i], 1'b0);
        dir_rows.delete();

        write_entries_in_use(4);
        // empty query: distance 0 to the empty slot 3, which has id 0
        dir_rows.push_back(query_row('0, 5'd0, 1'b1, 10'd0, ST_EXACT, 0));
        // duplicate sequences tie even at distance zero
        dir_rows.push_back(write_row(4, 48'h0000_0000_0FAC, 5'd4, 10'd77));
        dir_rows.push_back(write_row(5, 48'h0000_0000_0FAC, 5'd4, 10'd78));
        dir_rows.push_back(write_row(255, random_bases(), 5'd16, 10'd300));
        foreach (dir_rows[i]) send_item(dir_rows[i], 1'b0);
        dir_rows.delete();

        write_entries_in_use(6);
        dir_rows.push_back(query_row(48'h0000_0000_0FAC, 5'd4, 1'b1, '0, ST_UNCLEAR, 0));
        dir_rows.push_back(query_row(48'h0000_0000_0FAD, 5'd4, 1'b0, '0, ST_UNCLEAR, 0));
        dir_rows.push_back(query_row(48'h0000_0000_4FAC, 5'd5, 1'b0, '0, ST_UNCLEAR, 0));
        foreach (dir_rows[i]) send_item(dir_rows[i], 1'b0);
        dir_rows.delete();

        // Fill the whole table so any later setting reads written slots only.
        for (int s = 0; s < TABLE_DEPTH; s++)
            send_item(write_row(s, random_bases(), LEN_W'($urandom_range(0, 31)),
                                ID_W'($urandom_range(0, 1023))), 1'b1);

        // Random phases over several table sizes, largest kept short.
        foreach (sizes[p]) begin
            write_entries_in_use(sizes[p]);
            n = sizes[p];
            stall_kind = (p == 3) ? 1 : 0;
            phase_items = (n == 256) ? 60 : 380;
            for (int i = 0; i < phase_items; i++) begin
                if (p == 2 && i == 20) long_stall_req = 1'b1;
                if (p == 0 && i == 150) wait_drained();
                if ($urandom_range(0, 9) < 3) begin
                    // rewrite a searched slot; sometimes a duplicate of another
                    k = $urandom_range(0, n - 1);
                    if ($urandom_range(0, 4) == 0) begin
                        o = $urandom_range(0, n - 1);
                        r = write_row(k, shadow_bases[o], LEN_W'(shadow_len[o]),
                                      ID_W'($urandom()));
                    end else begin
                        r = write_row(k, random_bases(), LEN_W'($urandom_range(0, 31)),
                                      ID_W'($urandom()));
                    end
                end else begin
                    r = random_query(n);
                end
                send_item(r, 1'b1);
            end
        end

        // Register extreme above the table depth is clamped.
        write_entries_in_use(511);
        for (int i = 0; i < 10; i++) send_item(random_query(TABLE_DEPTH), 1'b1);

        stall_kind = 1;
        wait_drained();
        repeat (5000) @(posedge i_clk);

        $display("%0d queries and %0d results over table sizes 0 to 511,",
                 queries_sent, results_seen);
        $display("with ties, exact, corrected and empty searches under stalls.");
        if (mismatches == 0 && pending_matches.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     pending_matches.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bedc_pkg.sv
hw/rtl/bedc_cell.sv
hw/rtl/bedc_chain.sv
hw/rtl/barcode_edit_distance_corrector.sv
sim/barcode_edit_distance_corrector_tb.sv
